/* design/cpid_pkg.sv */
// shared types, register indexes and helpers of the cascade pid controller
`default_nettype none
package cpid_pkg;

	localparam int GAIN_W = 32;
	localparam int LIM_W  = 15;
	localparam int ERR_W  = 34;
	localparam int DIFF_W = 35;
	localparam int TERM_W = 45;
	localparam int ACC_W  = 47;
	localparam int VAL_W  = 32;

	localparam logic [2:0] REG_ANGLE_KP       = 3'd0;
	localparam logic [2:0] REG_ANGLE_KI       = 3'd1;
	localparam logic [2:0] REG_ANGLE_KD       = 3'd2;
	localparam logic [2:0] REG_VEL_KP         = 3'd3;
	localparam logic [2:0] REG_VEL_KI         = 3'd4;
	localparam logic [2:0] REG_VEL_KD         = 3'd5;
	localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;
	localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd7;

	localparam logic [GAIN_W-1:0] RST_ANGLE_KP = 32'd671088640;
	localparam logic [GAIN_W-1:0] RST_ANGLE_KI = 32'd0;
	localparam logic [GAIN_W-1:0] RST_ANGLE_KD = 32'd8388608;
	localparam logic [GAIN_W-1:0] RST_VEL_KP   = 32'd134218;
	localparam logic [GAIN_W-1:0] RST_VEL_KI   = 32'd1678;
	localparam logic [GAIN_W-1:0] RST_VEL_KD   = 32'd0;
	localparam logic [LIM_W-1:0]  RST_LIMIT    = 15'd10000;

	localparam logic [64:0] ROUND_HALF = 65'h800000;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ERR,
		CMD_MUL,
		CMD_WB,
		CMD_OUT
	} cmd_code_t;

	typedef enum logic [1:0] {
		SEL_P,
		SEL_D,
		SEL_I
	} term_sel_t;

	typedef enum logic {
		LOOP_VEL,
		LOOP_ANGLE
	} loop_t;

	typedef struct packed {
		cmd_code_t code;
		loop_t     loop;
		term_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic [GAIN_W-1:0] angle_kp;
		logic [GAIN_W-1:0] angle_ki;
		logic [GAIN_W-1:0] angle_kd;
		logic [GAIN_W-1:0] vel_kp;
		logic [GAIN_W-1:0] vel_ki;
		logic [GAIN_W-1:0] vel_kd;
		logic [LIM_W-1:0]  integral_limit;
		logic [LIM_W-1:0]  output_limit;
	} cfg_t;

	// symmetric clamp to +/- limit whole units, result in q15.16
	function automatic logic signed [VAL_W-1:0] clamp_sym(
		input logic signed [ACC_W-1:0] v,
		input logic [LIM_W-1:0] limit
	);
		logic signed [ACC_W-1:0] lim;
		logic signed [ACC_W-1:0] nlim;
		lim  = $signed(ACC_W'({limit, 16'b0}));
		nlim = -lim;
		if (v > lim) begin
			return lim[VAL_W-1:0];
		end else if (v < nlim) begin
			return nlim[VAL_W-1:0];
		end
		return v[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* design/cpid_if.sv */
// handshake channels of the cascade pid controller
`default_nettype none
interface cpid_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [15:0] target;
	logic signed [15:0] measured_angle;
	logic signed [15:0] measured_speed;

	modport source (output valid, output op, output target, output measured_angle,
		output measured_speed, input ready);
	modport sink (input valid, input op, input target, input measured_angle,
		input measured_speed, output ready);
endinterface

interface cpid_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface
`default_nettype wire

/* design/cpid_datapath.sv */
// loop state, shared gain multiplier, sums and clamps
`default_nettype none
module cpid_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cpid_pkg::cmd_t        cmd,
	input  cpid_pkg::cfg_t        cfg,
	input  wire signed [15:0]     target,
	input  wire signed [15:0]     measured_angle,
	input  wire signed [15:0]     measured_speed,
	output logic signed [31:0]    drive
);

	localparam int EW = cpid_pkg::ERR_W;
	localparam int DW = cpid_pkg::DIFF_W;
	localparam int TW = cpid_pkg::TERM_W;
	localparam int AW = cpid_pkg::ACC_W;
	localparam int VW = cpid_pkg::VAL_W;
	localparam int GW = cpid_pkg::GAIN_W;

	logic signed [VW-1:0] target_q, angle_q, speed_q, ref_q, drive_q;
	logic signed [EW-1:0] err_q;
	logic signed [DW-1:0] diff_q;
	logic signed [TW-1:0] p_q, d_q;
	logic signed [EW-1:0] angle_prev_q, vel_prev_q;
	logic signed [VW-1:0] angle_int_q, vel_int_q;
	logic [63:0]          prod_lo_s1;
	logic [DW-1:0]        prod_hi_s1;
	logic                 neg_s1;

	logic signed [VW-1:0] ref_sel, fb_sel, int_sel;
	logic signed [EW-1:0] prev_sel, err_new;
	logic signed [DW-1:0] diff_new, mul_op;
	logic [DW-1:0]        mag;
	logic [GW-1:0]        gain_sel;
	logic [64:0]          rnd;
	logic [43:0]          mag_r;
	logic signed [TW-1:0] term;
	logic signed [AW-1:0] int_sum, out_sum;
	logic signed [VW-1:0] int_new, out_new;

	always_comb begin
		ref_sel  = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? target_q : ref_q;
		fb_sel   = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? angle_q : speed_q;
		prev_sel = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? angle_prev_q : vel_prev_q;
		int_sel  = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? angle_int_q : vel_int_q;
		err_new  = EW'(ref_sel) - EW'(fb_sel);
		diff_new = DW'(err_new) - DW'(prev_sel);

		mul_op = (cmd.sel == cpid_pkg::SEL_D) ? diff_q : DW'(err_q);
		mag    = mul_op[DW-1] ? DW'(-mul_op) : DW'(mul_op);
		unique case (cmd.sel)
			cpid_pkg::SEL_P: begin
				gain_sel = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? cfg.angle_kp : cfg.vel_kp;
			end
			cpid_pkg::SEL_D: begin
				gain_sel = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? cfg.angle_kd : cfg.vel_kd;
			end
			cpid_pkg::SEL_I: begin
				gain_sel = (cmd.loop == cpid_pkg::LOOP_ANGLE) ? cfg.angle_ki : cfg.vel_ki;
			end
			default: begin
				gain_sel = '0;
			end
		endcase

		// round to nearest, ties away from zero, on the magnitude
		rnd   = 65'(prod_lo_s1) + cpid_pkg::ROUND_HALF;
		mag_r = 44'(rnd[64:24]) + 44'({prod_hi_s1, 8'b0});
		term  = neg_s1 ? -$signed(TW'(mag_r)) : $signed(TW'(mag_r));

		int_sum = AW'(int_sel) + AW'(term);
		int_new = cpid_pkg::clamp_sym(int_sum, cfg.integral_limit);
		out_sum = AW'(p_q) + AW'(d_q) + AW'(int_sel);
		out_new = cpid_pkg::clamp_sym(out_sum, cfg.output_limit);
	end

	// payload and intermediate registers
	always_ff @(posedge clk) begin
		unique case (cmd.code)
			cpid_pkg::CMD_LOAD: begin
				target_q <= {target, 16'b0};
				angle_q  <= {measured_angle, 16'b0};
				speed_q  <= {measured_speed, 16'b0};
				ref_q    <= {target, 16'b0};
			end
			cpid_pkg::CMD_ERR: begin
				err_q  <= err_new;
				diff_q <= diff_new;
			end
			cpid_pkg::CMD_MUL: begin
				prod_lo_s1 <= 64'(mag[31:0]) * 64'(gain_sel);
				prod_hi_s1 <= DW'(mag[DW-1:32]) * DW'(gain_sel);
				neg_s1     <= mul_op[DW-1];
			end
			cpid_pkg::CMD_WB: begin
				if (cmd.sel == cpid_pkg::SEL_P) begin
					p_q <= term;
				end else if (cmd.sel == cpid_pkg::SEL_D) begin
					d_q <= term;
				end
			end
			cpid_pkg::CMD_OUT: begin
				if (cmd.loop == cpid_pkg::LOOP_ANGLE) begin
					ref_q <= out_new;
				end else begin
					drive_q <= out_new;
				end
			end
			default: begin
			end
		endcase
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_prev_q <= '0;
			vel_prev_q   <= '0;
			angle_int_q  <= '0;
			vel_int_q    <= '0;
		end else if (cmd.code == cpid_pkg::CMD_WB && cmd.sel == cpid_pkg::SEL_I) begin
			if (cmd.loop == cpid_pkg::LOOP_ANGLE) begin
				angle_prev_q <= err_q;
				angle_int_q  <= int_new;
			end else begin
				vel_prev_q <= err_q;
				vel_int_q  <= int_new;
			end
		end
	end

	assign drive = drive_q;

endmodule
`default_nettype wire

/* design/cpid_ctrl.sv */
// sequencer for the loop steps and the result handshake
`default_nettype none
module cpid_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              in_op,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output cpid_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_MUL_P,
		S_WB_P,
		S_MUL_D,
		S_WB_D,
		S_MUL_I,
		S_WB_I,
		S_OUT
	} state_t;

	state_t         state_q;
	cpid_pkg::loop_t loop_q;
	logic           out_valid_q;
	logic           out_free;
	logic           emit;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == S_OUT) && (loop_q == cpid_pkg::LOOP_VEL) && out_free;

	always_comb begin
		cmd.loop = loop_q;
		cmd.sel  = cpid_pkg::SEL_P;
		cmd.code = cpid_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = cpid_pkg::CMD_LOAD;
				end
			end
			S_ERR: begin
				cmd.code = cpid_pkg::CMD_ERR;
			end
			S_MUL_P: begin
				cmd.code = cpid_pkg::CMD_MUL;
			end
			S_WB_P: begin
				cmd.code = cpid_pkg::CMD_WB;
			end
			S_MUL_D: begin
				cmd.code = cpid_pkg::CMD_MUL;
				cmd.sel  = cpid_pkg::SEL_D;
			end
			S_WB_D: begin
				cmd.code = cpid_pkg::CMD_WB;
				cmd.sel  = cpid_pkg::SEL_D;
			end
			S_MUL_I: begin
				cmd.code = cpid_pkg::CMD_MUL;
				cmd.sel  = cpid_pkg::SEL_I;
			end
			S_WB_I: begin
				cmd.code = cpid_pkg::CMD_WB;
				cmd.sel  = cpid_pkg::SEL_I;
			end
			S_OUT: begin
				if (loop_q == cpid_pkg::LOOP_ANGLE || out_free) begin
					cmd.code = cpid_pkg::CMD_OUT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loop_q      <= cpid_pkg::LOOP_VEL;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						loop_q  <= in_op ? cpid_pkg::LOOP_ANGLE : cpid_pkg::LOOP_VEL;
						state_q <= S_ERR;
					end
				end
				S_ERR:   state_q <= S_MUL_P;
				S_MUL_P: state_q <= S_WB_P;
				S_WB_P:  state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_WB_D;
				S_WB_D:  state_q <= S_MUL_I;
				S_MUL_I: state_q <= S_WB_I;
				S_WB_I:  state_q <= S_OUT;
				S_OUT: begin
					if (loop_q == cpid_pkg::LOOP_ANGLE) begin
						loop_q  <= cpid_pkg::LOOP_VEL;
						state_q <= S_ERR;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* design/cascade_pid_controller.sv */
// top level of the cascade pid controller: configuration registers, sequencer, datapath
// Each transfer on in_ch is one control tick and gives exactly one drive value on out_ch.
// A speed-only tick (op 0) runs the velocity loop alone; a cascade tick (op 1) runs the
// angle loop and then the velocity loop. Each loop walks 8 steps through one shared
// 35x32 gain multiplier (error, then proportional, derivative and integral products
// with rounding, then sum and clamp). A new tick is taken only once the last one has
// finished its steps and its result has gone to the output register, and one finished
// result is held on out_ch while the next tick is accepted. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while the block
// is idle, which the block itself does not enforce; integral_limit and output_limit
// keep the low 15 bits.
`default_nettype none
module cascade_pid_controller (
	input  wire               clk,
	input  wire               arst_n,
	cpid_in_if.sink           in_ch,
	cpid_out_if.source        out_ch,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data
);

	cpid_pkg::cfg_t cfg_q;
	cpid_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_kp       <= cpid_pkg::RST_ANGLE_KP;
			cfg_q.angle_ki       <= cpid_pkg::RST_ANGLE_KI;
			cfg_q.angle_kd       <= cpid_pkg::RST_ANGLE_KD;
			cfg_q.vel_kp         <= cpid_pkg::RST_VEL_KP;
			cfg_q.vel_ki         <= cpid_pkg::RST_VEL_KI;
			cfg_q.vel_kd         <= cpid_pkg::RST_VEL_KD;
			cfg_q.integral_limit <= cpid_pkg::RST_LIMIT;
			cfg_q.output_limit   <= cpid_pkg::RST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpid_pkg::REG_ANGLE_KP:       cfg_q.angle_kp <= cfg_data;
				cpid_pkg::REG_ANGLE_KI:       cfg_q.angle_ki <= cfg_data;
				cpid_pkg::REG_ANGLE_KD:       cfg_q.angle_kd <= cfg_data;
				cpid_pkg::REG_VEL_KP:         cfg_q.vel_kp <= cfg_data;
				cpid_pkg::REG_VEL_KI:         cfg_q.vel_ki <= cfg_data;
				cpid_pkg::REG_VEL_KD:         cfg_q.vel_kd <= cfg_data;
				cpid_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[14:0];
				cpid_pkg::REG_OUTPUT_LIMIT:   cfg_q.output_limit <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	cpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	cpid_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg_q),
		.target         (in_ch.target),
		.measured_angle (in_ch.measured_angle),
		.measured_speed (in_ch.measured_speed),
		.drive          (out_ch.drive)
	);

	// busy after a tick is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input taken while a tick is in progress");

	// every product is written back in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == cpid_pkg::CMD_MUL) |=> (cmd.code == cpid_pkg::CMD_WB))
		else $error("product not written back");

	// a shown drive lies within the output limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
			(($signed({1'b0, cfg_q.output_limit, 16'b0}) >= 33'(out_ch.drive)) &&
			 (-$signed({1'b0, cfg_q.output_limit, 16'b0}) <= 33'(out_ch.drive))))
		else $error("drive outside output limit");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench of the cascade pid controller with its own fixed-point predictor
module testbench;

	localparam logic OP_SPEED   = 1'b0;
	localparam logic OP_CASCADE = 1'b1;
	localparam bit [63:0] Q24_HALF = 64'h80_0000;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 116;

	typedef struct packed {
		logic        op;
		logic [15:0] target;
		logic [15:0] measured_angle;
		logic [15:0] measured_speed;
	} tick_t;

	typedef struct {
		longint prev_error;
		longint integral;
	} pid_state_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	cpid_in_if  in_ch ();
	cpid_out_if out_ch ();

	cascade_pid_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tick_t             pending_ticks[$];
	logic signed [31:0] drive_expected[$];
	cpid_pkg::cfg_t    gains;
	pid_state_t        loop_st [2];

	int  fails;
	int  ticks_taken;
	int  cascade_ticks;
	int  results_taken;
	int  reg_writes;
	int  quiet_cycles;
	int  ticks_seen;
	int  results_seen;
	int  gap_left;
	int  stall_left;
	bit  burst_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// (v * g) / 2^24 on the magnitude, rounded half away from zero
	function automatic longint scaled_product(longint v, bit [31:0] g);
		bit        neg;
		bit [63:0] m;
		bit [63:0] hi;
		bit [63:0] lo;
		bit [63:0] r;
		neg = v < 0;
		m = neg ? 64'(-v) : 64'(v);
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		r = ((hi * g) << 8) + ((lo * g + Q24_HALF) >> 24);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp_units(longint v, bit [14:0] lim_units);
		longint lim;
		lim = longint'(lim_units) * 65536;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint loop_update(cpid_pkg::loop_t l, longint reference,
			longint feedback);
		longint    err;
		longint    p_term;
		longint    d_term;
		bit [31:0] kp;
		bit [31:0] ki;
		bit [31:0] kd;
		if (l == cpid_pkg::LOOP_ANGLE) begin
			kp = gains.angle_kp;
			ki = gains.angle_ki;
			kd = gains.angle_kd;
		end else begin
			kp = gains.vel_kp;
			ki = gains.vel_ki;
			kd = gains.vel_kd;
		end
		err = reference - feedback;
		d_term = scaled_product(err - loop_st[int'(l)].prev_error, kd);
		p_term = scaled_product(err, kp);
		loop_st[int'(l)].prev_error = err;
		loop_st[int'(l)].integral = clamp_units(
			loop_st[int'(l)].integral + scaled_product(err, ki), gains.integral_limit);
		return clamp_units(p_term + d_term + loop_st[int'(l)].integral, gains.output_limit);
	endfunction

	function automatic logic signed [31:0] predict_drive(tick_t t);
		longint tgt;
		longint vel_ref;
		longint result;
		tgt = longint'($signed(t.target)) * 65536;
		vel_ref = tgt;
		if (t.op == OP_CASCADE) begin
			vel_ref = loop_update(cpid_pkg::LOOP_ANGLE, tgt,
				longint'($signed(t.measured_angle)) * 65536);
		end
		result = loop_update(cpid_pkg::LOOP_VEL, vel_ref,
			longint'($signed(t.measured_speed)) * 65536);
		return result[31:0];
	endfunction

	// result checking, prediction on each accepted tick, watchdog
	always @(posedge clk) begin
		logic signed [31:0] want;
		tick_t              t;
		bit                 moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				moved = 1'b1;
				results_taken++;
				if (drive_expected.size() == 0) begin
					$error("drive: expected none, got %0d", out_ch.drive);
					fails++;
				end else begin
					want = drive_expected.pop_front();
					if (want !== out_ch.drive) begin
						$error("drive: expected %0d, got %0d", want, out_ch.drive);
						fails++;
					end
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
				moved = 1'b1;
				t.op = in_ch.op;
				t.target = in_ch.target;
				t.measured_angle = in_ch.measured_angle;
				t.measured_speed = in_ch.measured_speed;
				drive_expected.push_back(predict_drive(t));
				ticks_taken++;
				if (t.op == OP_CASCADE) cascade_ticks++;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", quiet_cycles);
				$display("FAIL cascade_pid_controller");
				$finish;
			end
		end
	end

	// tick driver
	always @(negedge clk) begin
		tick_t t;
		logic  next_valid;
		if (arst_n) begin
			next_valid = in_ch.valid;
			if (in_ch.valid && ticks_taken != ticks_seen) begin
				ticks_seen = ticks_taken;
				next_valid = 1'b0;
				gap_left = burst_mode ? 0 : $urandom_range(0, 8);
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ticks.size() != 0) begin
					t = pending_ticks.pop_front();
					in_ch.op <= t.op;
					in_ch.target <= t.target;
					in_ch.measured_angle <= t.measured_angle;
					in_ch.measured_speed <= t.measured_speed;
					next_valid = 1'b1;
				end
			end
			in_ch.valid <= next_valid;
		end
	end

	// drive receiver with random back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (results_taken != results_seen) begin
				results_seen = results_taken;
				stall_left = burst_mode ? 0 : $urandom_range(0, 8);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_tick(logic op, int tgt, int ang, int spd);
		tick_t t;
		t.op = op;
		t.target = 16'(tgt);
		t.measured_angle = 16'(ang);
		t.measured_speed = 16'(spd);
		pending_ticks.push_back(t);
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_ch.valid === 1'b1
				|| drive_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			cpid_pkg::REG_ANGLE_KP:       gains.angle_kp = data;
			cpid_pkg::REG_ANGLE_KI:       gains.angle_ki = data;
			cpid_pkg::REG_ANGLE_KD:       gains.angle_kd = data;
			cpid_pkg::REG_VEL_KP:         gains.vel_kp = data;
			cpid_pkg::REG_VEL_KI:         gains.vel_ki = data;
			cpid_pkg::REG_VEL_KD:         gains.vel_kd = data;
			cpid_pkg::REG_INTEGRAL_LIMIT: gains.integral_limit = data[cpid_pkg::LIM_W-1:0];
			cpid_pkg::REG_OUTPUT_LIMIT:   gains.output_limit = data[cpid_pkg::LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [31:0] a_kp, logic [31:0] a_ki, logic [31:0] a_kd,
			logic [31:0] v_kp, logic [31:0] v_ki, logic [31:0] v_kd,
			logic [31:0] i_lim, logic [31:0] o_lim);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(cpid_pkg::REG_ANGLE_KP, a_kp);
		write_reg(cpid_pkg::REG_ANGLE_KI, a_ki);
		write_reg(cpid_pkg::REG_ANGLE_KD, a_kd);
		write_reg(cpid_pkg::REG_VEL_KP, v_kp);
		write_reg(cpid_pkg::REG_VEL_KI, v_ki);
		write_reg(cpid_pkg::REG_VEL_KD, v_kd);
		write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, i_lim);
		write_reg(cpid_pkg::REG_OUTPUT_LIMIT, o_lim);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// limits sometimes carry bits above the register width
	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd32767;
			2: return $urandom;
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	function automatic int rand_sample(int base);
		case ($urandom_range(0, 4))
			0: return int'($signed(16'($urandom)));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			2: return int'($urandom_range(0, 128)) - 64;
			default: return base + int'($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	task automatic push_random_tick();
		int tgt;
		tgt = rand_sample(0);
		push_tick(logic'($urandom_range(0, 1)), tgt, rand_sample(tgt), rand_sample(tgt));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_SPEED;
		in_ch.target = '0;
		in_ch.measured_angle = '0;
		in_ch.measured_speed = '0;
		out_ch.ready = 1'b0;
		fails = 0;
		ticks_taken = 0;
		cascade_ticks = 0;
		results_taken = 0;
		reg_writes = 0;
		quiet_cycles = 0;
		ticks_seen = 0;
		results_seen = 0;
		gap_left = 0;
		stall_left = 0;
		burst_mode = 1'b0;
		gains.angle_kp = cpid_pkg::RST_ANGLE_KP;
		gains.angle_ki = cpid_pkg::RST_ANGLE_KI;
		gains.angle_kd = cpid_pkg::RST_ANGLE_KD;
		gains.vel_kp = cpid_pkg::RST_VEL_KP;
		gains.vel_ki = cpid_pkg::RST_VEL_KI;
		gains.vel_kd = cpid_pkg::RST_VEL_KD;
		gains.integral_limit = cpid_pkg::RST_LIMIT;
		gains.output_limit = cpid_pkg::RST_LIMIT;
		foreach (loop_st[i]) begin
			loop_st[i].prev_error = 0;
			loop_st[i].integral = 0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset gains: extremes, integral build-up, speed ticks between cascade ticks
		push_tick(OP_SPEED, 0, 0, 0);
		push_tick(OP_SPEED, 32767, 0, -32768);
		push_tick(OP_SPEED, -32768, 0, 32767);
		push_tick(OP_SPEED, 100, 0, 0);
		push_tick(OP_SPEED, 100, 0, 0);
		push_tick(OP_SPEED, 100, 0, 0);
		push_tick(OP_CASCADE, 32767, -32768, -32768);
		push_tick(OP_CASCADE, -32768, 32767, 32767);
		push_tick(OP_CASCADE, 10, 9, 0);
		push_tick(OP_SPEED, 5, 0, 3);
		push_tick(OP_CASCADE, 10, 9, 0);
		push_tick(OP_CASCADE, 0, 0, 0);

		// largest gains and limits
		load_settings('1, '1, '1, '1, '1, '1, 32'd32767, 32'd32767);
		push_tick(OP_SPEED, 32767, 0, -32768);
		push_tick(OP_SPEED, -32768, 0, 32767);
		push_tick(OP_CASCADE, 32767, -32768, -32768);
		push_tick(OP_CASCADE, -32768, 32767, 32767);
		push_tick(OP_SPEED, 1, 0, 0);
		push_tick(OP_CASCADE, 0, 0, 1);

		// zero limits, then limit values wider than the register
		load_settings('1, '1, '1, '1, '1, '1, 32'd0, 32'd0);
		push_tick(OP_SPEED, 32767, 0, -32768);
		push_tick(OP_CASCADE, -32768, 32767, 32767);
		load_settings(32'h0100_0000, 32'h0001_0000, 32'h0080_0000, 32'h0100_0000,
			32'h0001_0000, 32'h0040_0000, 32'hFFFF_8005, 32'h1234_0007);
		push_tick(OP_SPEED, 9, 0, 0);
		push_tick(OP_CASCADE, 9, 0, 0);
		push_tick(OP_SPEED, -9, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_settings(cpid_pkg::RST_ANGLE_KP, cpid_pkg::RST_ANGLE_KI,
					cpid_pkg::RST_ANGLE_KD, cpid_pkg::RST_VEL_KP, cpid_pkg::RST_VEL_KI,
					cpid_pkg::RST_VEL_KD, 32'(cpid_pkg::RST_LIMIT),
					32'(cpid_pkg::RST_LIMIT));
				1: load_settings('1, '1, '1, '1, '1, '1, 32'd32767, 32'd32767);
				2: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					rand_gain(), rand_gain(), 32'd0, 32'd32767);
				default: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					rand_gain(), rand_gain(), rand_limit(), rand_limit());
			endcase
			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				if (i % 40 == 0) burst_mode = $urandom_range(0, 2) == 0;
				// let the block drain completely halfway through each phase
				if (i == TICKS_PER_PHASE / 2) wait_idle();
				push_random_tick();
			end
		end

		wait_idle();
		burst_mode = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d ticks (%0d cascade) and %0d drive results checked, %0d register writes",
			ticks_taken, cascade_ticks, results_taken, reg_writes);
		if (fails == 0) begin
			$display("PASS cascade_pid_controller");
		end else begin
			$display("%0d mismatches", fails);
			$display("FAIL cascade_pid_controller");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/cpid_pkg.sv
design/cpid_if.sv
design/cpid_datapath.sv
design/cpid_ctrl.sv
design/cascade_pid_controller.sv
sim/testbench.sv
